@@ rtl/rmq_pkg.sv @@
// Shared types and constants for the rotation matrix to quaternion block.
package rmq_pkg;

    // Radicand bits consumed by one square-root digit step.
    localparam int DIGIT_BITS = 2;

    // Sign of an off-diagonal difference.
    typedef enum logic [1:0] {
        SGN_ZERO = 2'd0,
        SGN_POS  = 2'd1,
        SGN_NEG  = 2'd2
    } sign_t;

    // Signs of the three vector parts, carried alongside the square roots.
    typedef struct packed {
        sign_t sx;
        sign_t sy;
        sign_t sz;
    } signs_t;

endpackage

@@ rtl/rmq_isqrt_pipe.sv @@
// Pipelined integer square root, one root bit per register stage.
module rmq_isqrt_pipe #(
    parameter int ROOT_BITS = 15
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic [2*ROOT_BITS-1:0]   in_rad,
    input  logic                     in_sat,
    output logic [ROOT_BITS-1:0]     out_root,
    output logic                     out_sat
);

    localparam int D     = rmq_pkg::DIGIT_BITS;
    localparam int RAD_W = 2 * ROOT_BITS;
    localparam int REM_W = ROOT_BITS + 2;

    logic [RAD_W-1:0]     rad_reg  [0:ROOT_BITS-1];
    logic [REM_W-1:0]     rem_reg  [1:ROOT_BITS-1];
    logic [ROOT_BITS-1:0] root_reg [1:ROOT_BITS];
    logic                 sat_reg  [0:ROOT_BITS];

    // Entry stage holds the radicand and the saturation flag.
    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg[0] <= in_rad;
            sat_reg[0] <= in_sat;
        end
    end

    // Each stage brings down two radicand bits and decides one root bit.
    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_step
        logic [REM_W-1:0]     rem_cur;
        logic [REM_W-1:0]     rem_shift;
        logic [REM_W-1:0]     trial;
        logic [ROOT_BITS-1:0] root_cur;
        logic [ROOT_BITS-1:0] root_next;
        logic                 ge;

        if (k == 0) begin : g_first
            assign rem_cur  = '0;
            assign root_cur = '0;
        end else begin : g_rest
            assign rem_cur  = rem_reg[k];
            assign root_cur = root_reg[k];
        end

        assign rem_shift = {rem_cur[REM_W-D-1:0], rad_reg[k][RAD_W-1 -: D]};
        assign trial     = {root_cur, {(D-1){1'b0}}, 1'b1};
        assign ge        = (rem_shift >= trial);
        assign root_next = {root_cur[ROOT_BITS-2:0], ge};

        always_ff @(posedge aclk) begin
            if (en) begin
                root_reg[k+1] <= root_next;
                sat_reg[k+1]  <= sat_reg[k];
            end
        end

        // The last stage passes on no remainder or radicand.
        if (k < ROOT_BITS-1) begin : g_carry
            logic [REM_W-1:0] rem_next;

            assign rem_next = ge ? (rem_shift - trial) : rem_shift;

            always_ff @(posedge aclk) begin
                if (en) begin
                    rem_reg[k+1] <= rem_next;
                    rad_reg[k+1] <= rad_reg[k] << D;
                end
            end
        end
    end

    assign out_root = root_reg[ROOT_BITS];
    assign out_sat  = sat_reg[ROOT_BITS];

endmodule

@@ rtl/rotation_matrix_to_quaternion_top.sv @@
// Top level of the rotation matrix to quaternion converter.
//
//  channel   direction  ports                     handshake
//  s_        in         s_m00 .. s_m22 (Q1.14)    s_valid / s_ready
//  m_        out        m_qw, m_qx, m_qy, m_qz    m_valid / m_ready
//
// One item enters per cycle while the output is not held; each result passes the
// entry register, the square-root pipeline, which resolves one root bit per stage
// over FRAC_BITS + 1 stages, and the output register.
// Reset clears only the valid bits. When m_ready is low with a result waiting,
// the whole pipeline holds and s_ready drops; nothing is lost or repeated.
module rotation_matrix_to_quaternion_top #(
    parameter int FRAC_BITS = 14
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_m00,
    input  logic signed [15:0] s_m01,
    input  logic signed [15:0] s_m02,
    input  logic signed [15:0] s_m10,
    input  logic signed [15:0] s_m11,
    input  logic signed [15:0] s_m12,
    input  logic signed [15:0] s_m20,
    input  logic signed [15:0] s_m21,
    input  logic signed [15:0] s_m22,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [14:0]        m_qw,
    output logic signed [15:0] m_qx,
    output logic signed [15:0] m_qy,
    output logic signed [15:0] m_qz
);

    localparam int ROOT_BITS = FRAC_BITS + 1;
    localparam int RAD_W     = 2 * ROOT_BITS;
    localparam int SUM_W     = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 4;
    localparam int MAG_W     = FRAC_BITS + 1;
    localparam int LANES     = 4;

    localparam logic signed [SUM_W-1:0] ONE_S  = SUM_W'(1) <<< FRAC_BITS;
    localparam logic signed [SUM_W-1:0] FOUR_S = SUM_W'(4) <<< FRAC_BITS;
    localparam logic [MAG_W-1:0]        ONE_M  = MAG_W'(1) << FRAC_BITS;

    // Sign of a 17-bit difference.
    function automatic rmq_pkg::sign_t sign_of(input logic signed [16:0] d);
        rmq_pkg::sign_t s;
        if (d == '0) begin
            s = rmq_pkg::SGN_ZERO;
        end else if (d[16]) begin
            s = rmq_pkg::SGN_NEG;
        end else begin
            s = rmq_pkg::SGN_POS;
        end
        return s;
    endfunction

    // Apply a sign code to a magnitude and cut it to the field width.
    function automatic logic [15:0] apply_sign(input logic [MAG_W-1:0] mag,
                                               input rmq_pkg::sign_t s);
        logic [63:0] mag64;
        logic [63:0] val;
        mag64 = 64'(mag);
        unique case (s)
            rmq_pkg::SGN_POS: val = mag64;
            rmq_pkg::SGN_NEG: val = 64'(0) - mag64;
            default:          val = '0;
        endcase
        return val[15:0];
    endfunction

    logic                 adv;
    logic                 valid_reg [0:ROOT_BITS];
    rmq_pkg::signs_t      signs_reg [0:ROOT_BITS];
    rmq_pkg::signs_t      signs_next;

    logic signed [SUM_W-1:0] e00, e11, e22;
    logic signed [SUM_W-1:0] rsum     [LANES];
    logic [RAD_W-1:0]        lane_rad [LANES];
    logic                    lane_sat [LANES];
    logic [ROOT_BITS-1:0]    lane_root[LANES];
    logic                    lane_osat[LANES];
    logic [MAG_W-1:0]        lane_mag [LANES];

    logic                    m_valid_reg;
    logic [14:0]             m_qw_reg;
    logic [15:0]             m_qx_reg, m_qy_reg, m_qz_reg;
    logic [14:0]             qw_next;
    logic [15:0]             qx_next, qy_next, qz_next;
    logic [63:0]             qw_wide;

    // The pipeline moves whenever the output register is empty or being taken.
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // Radicands for the four diagonal sign patterns.
    assign e00 = SUM_W'(s_m00);
    assign e11 = SUM_W'(s_m11);
    assign e22 = SUM_W'(s_m22);

    assign rsum[0] = ONE_S + e00 + e11 + e22;
    assign rsum[1] = ONE_S + e00 - e11 - e22;
    assign rsum[2] = ONE_S - e00 + e11 - e22;
    assign rsum[3] = ONE_S - e00 - e11 + e22;

    // Clamp each radicand to 0 .. 4.0 and scale it by 2^FRAC_BITS.
    for (genvar i = 0; i < LANES; i++) begin : g_lane
        logic neg;

        assign neg         = rsum[i][SUM_W-1];
        assign lane_sat[i] = !neg && (rsum[i] >= FOUR_S);
        assign lane_rad[i] = (neg || lane_sat[i]) ? '0 :
                             {rsum[i][FRAC_BITS+1:0], {FRAC_BITS{1'b0}}};

        rmq_isqrt_pipe #(
            .ROOT_BITS (ROOT_BITS)
        ) u_isqrt (
            .aclk     (aclk),
            .en       (adv),
            .in_rad   (lane_rad[i]),
            .in_sat   (lane_sat[i]),
            .out_root (lane_root[i]),
            .out_sat  (lane_osat[i])
        );

        assign lane_mag[i] = lane_osat[i] ? ONE_M :
                             {1'b0, lane_root[i][ROOT_BITS-1:1]};
    end

    // Signs of the off-diagonal differences.
    always_comb begin
        signs_next.sx = sign_of(17'(s_m21) - 17'(s_m12));
        signs_next.sy = sign_of(17'(s_m02) - 17'(s_m20));
        signs_next.sz = sign_of(17'(s_m10) - 17'(s_m01));
    end

    // Valid bits and signs travel in step with the square-root stages.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= ROOT_BITS; k++) begin
                valid_reg[k] <= 1'b0;
            end
        end else if (adv) begin
            valid_reg[0] <= s_valid;
            for (int k = 1; k <= ROOT_BITS; k++) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            signs_reg[0] <= signs_next;
            for (int k = 1; k <= ROOT_BITS; k++) begin
                signs_reg[k] <= signs_reg[k-1];
            end
        end
    end

    // Format the result item.
    always_comb begin
        qw_wide = 64'(lane_mag[0]);
        qw_next = qw_wide[14:0];
        qx_next = apply_sign(lane_mag[1], signs_reg[ROOT_BITS].sx);
        qy_next = apply_sign(lane_mag[2], signs_reg[ROOT_BITS].sy);
        qz_next = apply_sign(lane_mag[3], signs_reg[ROOT_BITS].sz);
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= valid_reg[ROOT_BITS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_qw_reg <= qw_next;
            m_qx_reg <= qx_next;
            m_qy_reg <= qy_next;
            m_qz_reg <= qz_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_qw    = m_qw_reg;
    assign m_qx    = m_qx_reg;
    assign m_qy    = m_qy_reg;
    assign m_qz    = m_qz_reg;

endmodule

@@ test/tb_rotation_matrix_to_quaternion_top.sv @@
// Self-checking testbench for the rotation matrix to quaternion converter.
module tb_rotation_matrix_to_quaternion_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS  = 14;
    localparam int LATENCY    = FRAC_BITS + 2;
    localparam int N_RANDOM   = 1500;
    localparam int N_CALM     = 150;
    localparam int CYCLE_CAP  = 400000;
    localparam int PRINT_CAP  = 30;

    // One matrix as presented on the input channel.
    typedef struct packed {
        logic signed [15:0] m00, m01, m02;
        logic signed [15:0] m10, m11, m12;
        logic signed [15:0] m20, m21, m22;
    } matrix_t;

    // One quaternion as it leaves the result channel.
    typedef struct packed {
        logic [14:0]        qw;
        logic signed [15:0] qx, qy, qz;
    } quat_t;

    // Predicts the quaternion of every accepted matrix and checks results in order.
    class quat_scoreboard;
        quat_t pending_quats[$];
        int    errors;
        int    checked;

        function new();
            errors  = 0;
            checked = 0;
        endfunction

        // Floor of the square root, one result bit at a time.
        function longint unsigned root_floor(longint unsigned v);
            longint unsigned res;
            longint unsigned trial;
            res = 0;
            for (int i = 16; i >= 0; i--) begin
                trial = res | (longint'(1) << i);
                if (trial * trial <= v) res = trial;
            end
            return res;
        endfunction

        // Magnitude of one component from its radicand, clamped to 0 .. 4.0.
        function longint unsigned part_magnitude(longint r);
            longint one;
            one = longint'(1) << FRAC_BITS;
            if (r < 0) r = 0;
            if (r > 4 * one) r = 4 * one;
            return root_floor(longint'(r) << FRAC_BITS) >> 1;
        endfunction

        function rmq_pkg::sign_t diff_sign(longint d);
            if (d == 0) return rmq_pkg::SGN_ZERO;
            return (d < 0) ? rmq_pkg::SGN_NEG : rmq_pkg::SGN_POS;
        endfunction

        // Vector part: magnitude with the sign of its off-diagonal difference.
        function logic signed [15:0] vector_part(longint unsigned mag, rmq_pkg::sign_t s);
            logic [15:0] m16;
            m16 = mag[15:0];
            unique case (s)
                rmq_pkg::SGN_POS: return m16;
                rmq_pkg::SGN_NEG: return 16'(16'd0 - m16);
                default:          return 16'sd0;
            endcase
        endfunction

        function quat_t matrix_to_quat(matrix_t a);
            longint one;
            longint unsigned w, x, y, z;
            quat_t q;
            one = longint'(1) << FRAC_BITS;
            w = part_magnitude(one + a.m00 + a.m11 + a.m22);
            x = part_magnitude(one + a.m00 - a.m11 - a.m22);
            y = part_magnitude(one - a.m00 + a.m11 - a.m22);
            z = part_magnitude(one - a.m00 - a.m11 + a.m22);
            q.qw = w[14:0];
            q.qx = vector_part(x, diff_sign(longint'(a.m21) - longint'(a.m12)));
            q.qy = vector_part(y, diff_sign(longint'(a.m02) - longint'(a.m20)));
            q.qz = vector_part(z, diff_sign(longint'(a.m10) - longint'(a.m01)));
            return q;
        endfunction

        task report(string msg);
            if (errors < PRINT_CAP) $display("mismatch: %s", msg);
            errors++;
        endtask

        function void note_matrix(matrix_t a);
            pending_quats.push_back(matrix_to_quat(a));
        endfunction

        task check_result(quat_t got);
            quat_t want;
            if (pending_quats.size() == 0) begin
                report($sformatf("result %0d arrived with no item pending", checked));
                return;
            end
            want = pending_quats.pop_front();
            if (got.qw !== want.qw)
                report($sformatf("result %0d qw %0d, predicted %0d", checked, got.qw, want.qw));
            if (got.qx !== want.qx)
                report($sformatf("result %0d qx %0d, predicted %0d", checked, got.qx, want.qx));
            if (got.qy !== want.qy)
                report($sformatf("result %0d qy %0d, predicted %0d", checked, got.qy, want.qy));
            if (got.qz !== want.qz)
                report($sformatf("result %0d qz %0d, predicted %0d", checked, got.qz, want.qz));
            checked++;
        endtask
    endclass

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic signed [15:0] s_m00, s_m01, s_m02, s_m10, s_m11, s_m12, s_m20, s_m21, s_m22;
    logic               m_valid;
    logic               m_ready;
    logic [14:0]        m_qw;
    logic signed [15:0] m_qx, m_qy, m_qz;

    quat_scoreboard sb;
    bit             calm = 1'b0;
    int             cycles = 0;
    int             n_directed = 0;
    int             n_rotation = 0;
    int             n_unit = 0;
    int             n_wild = 0;

    rotation_matrix_to_quaternion_top #(.FRAC_BITS(FRAC_BITS)) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_m00   (s_m00),
        .s_m01   (s_m01),
        .s_m02   (s_m02),
        .s_m10   (s_m10),
        .s_m11   (s_m11),
        .s_m12   (s_m12),
        .s_m20   (s_m20),
        .s_m21   (s_m21),
        .s_m22   (s_m22),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_qw    (m_qw),
        .m_qx    (m_qx),
        .m_qy    (m_qy),
        .m_qz    (m_qz)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Result monitor: every accepted result goes to the scoreboard.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(quat_t'{qw: m_qw, qx: m_qx, qy: m_qy, qz: m_qz});
    end

    // Result side back-pressure: stall bursts between runs of steady acceptance.
    initial begin
        m_ready <= 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge aclk);
            if (!calm && $urandom_range(0, 1) == 1) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
        end
    end

    function automatic matrix_t mk(int a00, int a01, int a02, int a10, int a11, int a12,
                                   int a20, int a21, int a22);
        matrix_t a;
        a = '{m00: 16'(a00), m01: 16'(a01), m02: 16'(a02),
              m10: 16'(a10), m11: 16'(a11), m12: 16'(a12),
              m20: 16'(a20), m21: 16'(a21), m22: 16'(a22)};
        return a;
    endfunction

    // Real value to Q1.14, rounded and held within -1.0 .. 1.0.
    function automatic int to_q14(real v);
        int t;
        t = $rtoi(v * 16384.0 + ((v >= 0.0) ? 0.5 : -0.5));
        if (t > 16384) t = 16384;
        if (t < -16384) t = -16384;
        return t;
    endfunction

    // Quantized rotation matrix from a random quaternion.
    function automatic matrix_t random_rotation();
        real w, x, y, z, n;
        w = real'($urandom_range(0, 65535)) - 32768.0;
        x = real'($urandom_range(0, 65535)) - 32768.0;
        y = real'($urandom_range(0, 65535)) - 32768.0;
        z = real'($urandom_range(0, 65535)) - 32768.0;
        n = $sqrt(w * w + x * x + y * y + z * z);
        if (n < 1.0) return mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384);
        w = w / n; x = x / n; y = y / n; z = z / n;
        return mk(to_q14(1.0 - 2.0 * (y * y + z * z)), to_q14(2.0 * (x * y - z * w)),
                  to_q14(2.0 * (x * z + y * w)), to_q14(2.0 * (x * y + z * w)),
                  to_q14(1.0 - 2.0 * (x * x + z * z)), to_q14(2.0 * (y * z - x * w)),
                  to_q14(2.0 * (x * z - y * w)), to_q14(2.0 * (y * z + x * w)),
                  to_q14(1.0 - 2.0 * (x * x + y * y)));
    endfunction

    // Elements within -1.0 .. 1.0, with off-diagonal pairs often made equal.
    function automatic matrix_t random_unit_range();
        matrix_t a;
        a.m00 = 16'($urandom_range(0, 32768)) - 16'sd16384;
        a.m01 = 16'($urandom_range(0, 32768)) - 16'sd16384;
        a.m02 = 16'($urandom_range(0, 32768)) - 16'sd16384;
        a.m10 = 16'($urandom_range(0, 32768)) - 16'sd16384;
        a.m11 = 16'($urandom_range(0, 32768)) - 16'sd16384;
        a.m12 = 16'($urandom_range(0, 32768)) - 16'sd16384;
        a.m20 = 16'($urandom_range(0, 32768)) - 16'sd16384;
        a.m21 = 16'($urandom_range(0, 32768)) - 16'sd16384;
        a.m22 = 16'($urandom_range(0, 32768)) - 16'sd16384;
        if ($urandom_range(0, 3) == 0) a.m21 = a.m12;
        if ($urandom_range(0, 3) == 0) a.m02 = a.m20;
        if ($urandom_range(0, 3) == 0) a.m10 = a.m01;
        return a;
    endfunction

    // Any 16-bit pattern in every element.
    function automatic matrix_t random_wild();
        matrix_t     a;
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        a = raw[143:0];
        return a;
    endfunction

    // Present one matrix and hold it until the block takes it.
    task automatic send_matrix(matrix_t a);
        s_valid <= 1'b1;
        s_m00 <= a.m00; s_m01 <= a.m01; s_m02 <= a.m02;
        s_m10 <= a.m10; s_m11 <= a.m11; s_m12 <= a.m12;
        s_m20 <= a.m20; s_m21 <= a.m21; s_m22 <= a.m22;
        do @(posedge aclk); while (s_ready !== 1'b1);
        sb.note_matrix(a);
    endtask

    // Occasional gap on the input side before the next item.
    task automatic maybe_pause();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
    endtask

    // Main sequence: reset, directed matrices, random matrices, drain.
    initial begin
        matrix_t directed[$];
        int      kind;
        sb = new();
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_m00 <= '0; s_m01 <= '0; s_m02 <= '0;
        s_m10 <= '0; s_m11 <= '0; s_m12 <= '0;
        s_m20 <= '0; s_m21 <= '0; s_m22 <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Identity, zero, all elements at 1.0 or -1.0, and the field extremes.
        directed.push_back(mk(16384, 0, 0, 0, 16384, 0, 0, 0, 16384));
        directed.push_back(mk(0, 0, 0, 0, 0, 0, 0, 0, 0));
        directed.push_back(mk(16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384, 16384));
        directed.push_back(mk(-16384, -16384, -16384, -16384, -16384, -16384,
                              -16384, -16384, -16384));
        directed.push_back(mk(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        directed.push_back(mk(-32768, -32768, -32768, -32768, -32768, -32768,
                              -32768, -32768, -32768));
        // Half turns about each axis: the scalar part vanishes.
        directed.push_back(mk(16384, 0, 0, 0, -16384, 0, 0, 0, -16384));
        directed.push_back(mk(-16384, 0, 0, 0, 16384, 0, 0, 0, -16384));
        directed.push_back(mk(-16384, 0, 0, 0, -16384, 0, 0, 0, 16384));
        // Quarter turns about z, x and y in both directions.
        directed.push_back(mk(0, -16384, 0, 16384, 0, 0, 0, 0, 16384));
        directed.push_back(mk(0, 16384, 0, -16384, 0, 0, 0, 0, 16384));
        directed.push_back(mk(16384, 0, 0, 0, 0, -16384, 0, 16384, 0));
        directed.push_back(mk(16384, 0, 0, 0, 0, 16384, 0, -16384, 0));
        directed.push_back(mk(0, 0, 16384, 0, 16384, 0, -16384, 0, 0));
        directed.push_back(mk(0, 0, -16384, 0, 16384, 0, 16384, 0, 0));
        // Radicands far below zero, then far above 4.0 with the others below zero.
        directed.push_back(mk(-32768, 5, -7, 9, -32768, 11, -13, 15, -32768));
        directed.push_back(mk(32767, -1, 1, 1, 32767, -1, -1, 1, 32767));
        // Off-diagonal differences at their widest, positive and negative.
        directed.push_back(mk(0, -32768, 32767, 32767, 0, -32768, -32768, 32767, 0));
        directed.push_back(mk(0, 32767, -32768, -32768, 0, 32767, 32767, -32768, 0));
        // Alternating bit patterns.
        directed.push_back(mk(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555,
                              16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
        directed.push_back(mk(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA,
                              16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
        // Radicand one step below zero and exactly at 4.0.
        directed.push_back(mk(-16384, 3, 3, 3, -1, 3, 3, 3, 0));
        directed.push_back(mk(16384, 2, 1, 1, 16384, 2, 1, 1, 16384));

        foreach (directed[i]) begin
            maybe_pause();
            send_matrix(directed[i]);
            n_directed++;
        end

        // Random part: genuine rotations half the time, else in-range elements or noise.
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i == N_RANDOM - N_CALM) calm = 1'b1;
            maybe_pause();
            kind = $urandom_range(0, 7);
            if (kind < 4) begin
                send_matrix(random_rotation());
                n_rotation++;
            end else if (kind < 6) begin
                send_matrix(random_unit_range());
                n_unit++;
            end else begin
                send_matrix(random_wild());
                n_wild++;
            end
        end
        s_valid <= 1'b0;

        // Drain everything still in the pipeline, then allow for stray results.
        while (sb.pending_quats.size() != 0) @(posedge aclk);
        repeat (LATENCY + 8) @(posedge aclk);

        $display("covered %0d directed matrices, %0d rotations, %0d in-range and %0d raw",
                 n_directed, n_rotation, n_unit, n_wild);
        $display("checked %0d quaternions, %0d mismatches", sb.checked, sb.errors);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rmq_pkg.sv
rtl/rmq_isqrt_pipe.sv
rtl/rotation_matrix_to_quaternion_top.sv
test/tb_rotation_matrix_to_quaternion_top.sv
